/* design/hpr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hex packet receiver package
// Shared constants, operation codes, the response record and the hex digit
// decoder used by the receiver and its checker.
// ----------------------------------------------------------------------------
package hpr_pkg;

   // Receive buffer size in bytes (2 to 128; byte indices are OUT_IDX_W bits wide).
   localparam int unsigned BUF_BYTES = 128;
   localparam int unsigned IDX_W     = 8;
   localparam int unsigned OUT_IDX_W = 7;

   typedef logic [1:0] op_type;

   localparam op_type OP_CHAR        = 2'd0;
   localparam op_type OP_RX_RESET    = 2'd1;
   localparam op_type OP_CLR_ATI     = 2'd2;
   localparam op_type OP_CLR_RECEIPT = 2'd3;

   localparam logic [7:0] CH_UPPER_S = 8'h53;
   localparam logic [7:0] CH_UPPER_N = 8'h4E;
   localparam logic [7:0] CH_UPPER_K = 8'h4B;
   localparam logic [7:0] CH_UPPER_I = 8'h49;
   localparam logic [7:0] CH_LOWER_I = 8'h69;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] HEX_TEN    = 8'd10;

   localparam logic [IDX_W-1:0] BUF_END = IDX_W'(BUF_BYTES);
   localparam logic [IDX_W-1:0] MIN_LEN = IDX_W'(2);

   typedef struct packed {
      logic                 byte_valid;
      logic [OUT_IDX_W-1:0] byte_index;
      logic [7:0]           byte_value;
      logic                 packet_done;
      logic                 ati_seen;
      logic                 receipt_seen;
      logic                 receipt_ack;
      logic                 has_data;
   } rsp_type;

   // Returns {digit is hex, nibble value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
         d = c - CH_DIGIT_0;
         return {1'b1, d[3:0]};
      end
      if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
         d = c - CH_UPPER_A + HEX_TEN;
         return {1'b1, d[3:0]};
      end
      if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
         d = c - CH_LOWER_A + HEX_TEN;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

endpackage
`default_nettype wire

/* design/hex_packet_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hex packet receiver
// Decodes a stream of serial characters into control flags and the bytes of
// a hex-encoded packet, one response for every request.
// ----------------------------------------------------------------------------
//
//   Channel    Direction  Handshake             Payload
//   req_       in         req_valid/req_stall   req_op, req_rx_char
//   rsp_       out        rsp_valid/rsp_stall   byte, index and flag fields
//
// Every request is decoded in the cycle it is accepted and its response is
// registered, so one request per cycle is sustained while the output is not
// stalled. The receiver state (flags, nibble phase, write index and packet
// length) updates at the accepting edge, which lets back-to-back requests
// see each other's effects. A two-entry output (response register plus a
// skid register) means a stalled response does not block the next request;
// req_stall rises only once both entries are occupied, and comes from a
// register. Reset is synchronous and clears all receiver state.
//
module hex_packet_receiver (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [1:0]                         req_op,
   input  wire  [7:0]                         req_rx_char,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic                               rsp_byte_valid,
   output logic [hpr_pkg::OUT_IDX_W-1:0]      rsp_byte_index,
   output logic [7:0]                         rsp_byte_value,
   output logic                               rsp_packet_done,
   output logic                               rsp_ati_seen,
   output logic                               rsp_receipt_seen,
   output logic                               rsp_receipt_ack,
   output logic                               rsp_has_data
);
   import hpr_pkg::*;

   // Receiver state.
   logic             ati_ff, ati_in;
   logic             receipt_ff, receipt_in;
   logic             ack_ff, ack_in;
   logic             low_next_ff, low_next_in;
   logic             ready_ff, ready_in;
   logic             skip_ff, skip_in;
   logic             decoding_ff, decoding_in;
   logic [IDX_W-1:0] widx_ff, widx_in;
   logic [3:0]       pend_ff, pend_in;
   logic [15:0]      len_ff, len_in;

   // Output staging.
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;

   logic             req_accept;
   logic             rsp_take;
   rsp_type          result;
   logic [4:0]       hex;
   logic [7:0]       new_byte;
   logic [IDX_W-1:0] widx_next;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid & ~skid_valid_ff;
   assign rsp_take   = out_valid_ff & ~rsp_stall;
   assign hex        = hex_digit(req_rx_char);

   // Character decoding. The checks follow a strict priority: a skipped
   // character is dropped outright, then the control letters, then packet
   // start and hex data.
   always_comb begin
      ati_in      = ati_ff;
      receipt_in  = receipt_ff;
      ack_in      = ack_ff;
      low_next_in = low_next_ff;
      ready_in    = ready_ff;
      skip_in     = skip_ff;
      decoding_in = decoding_ff;
      widx_in     = widx_ff;
      pend_in     = pend_ff;
      len_in      = len_ff;
      new_byte    = {pend_ff, hex[3:0]};
      widx_next   = widx_ff + IDX_W'(1);
      result      = '0;

      case (req_op)
         OP_CHAR: begin
            if (skip_ff) begin
               skip_in = 1'b0;
            end else if (req_rx_char == CH_UPPER_I || req_rx_char == CH_LOWER_I) begin
               ati_in = 1'b1;
            end else if (req_rx_char == CH_UPPER_N) begin
               receipt_in = 1'b1;
               ack_in     = 1'b0;
            end else if (req_rx_char == CH_UPPER_K) begin
               receipt_in = 1'b1;
               ack_in     = 1'b1;
            end else begin
               // A start letter while no packet is ready restarts the index
               // but keeps the nibble phase.
               if (req_rx_char == CH_UPPER_S && !ready_ff) begin
                  widx_in     = '0;
                  skip_in     = 1'b1;
                  decoding_in = 1'b1;
               end
               widx_next = widx_in + IDX_W'(1);
               if (decoding_in && hex[4]) begin
                  if (!low_next_ff) begin
                     pend_in     = hex[3:0];
                     low_next_in = 1'b1;
                  end else begin
                     low_next_in       = 1'b0;
                     result.byte_valid = 1'b1;
                     result.byte_index = widx_in[OUT_IDX_W-1:0];
                     result.byte_value = new_byte;
                     if (widx_in == '0) begin
                        len_in[7:0] = new_byte;
                     end else if (widx_in == IDX_W'(1)) begin
                        len_in[15:8] = new_byte;
                     end
                     widx_in = widx_next;
                     // Stop on a full buffer or once the announced length
                     // has arrived.
                     if (widx_next == BUF_END ||
                         (widx_next >= MIN_LEN && len_in == 16'(widx_next))) begin
                        ready_in    = 1'b1;
                        decoding_in = 1'b0;
                     end
                  end
               end
            end
         end
         OP_RX_RESET: begin
            low_next_in = 1'b0;
            ready_in    = 1'b0;
            skip_in     = 1'b0;
            decoding_in = 1'b0;
         end
         OP_CLR_ATI: begin
            ati_in = 1'b0;
         end
         default: begin
            receipt_in = 1'b0;
         end
      endcase

      result.packet_done  = ready_in;
      result.ati_seen     = ati_in;
      result.receipt_seen = receipt_in;
      result.receipt_ack  = ack_in;
      result.has_data     = ati_in | ready_in | receipt_in;
   end

   // Output register with a skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (req_accept) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_in        = skid_ff;
         out_valid_in  = skid_valid_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ati_ff        <= 1'b0;
         receipt_ff    <= 1'b0;
         ack_ff        <= 1'b0;
         low_next_ff   <= 1'b0;
         ready_ff      <= 1'b0;
         skip_ff       <= 1'b0;
         decoding_ff   <= 1'b0;
         widx_ff       <= '0;
         pend_ff       <= '0;
         len_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            ati_ff      <= ati_in;
            receipt_ff  <= receipt_in;
            ack_ff      <= ack_in;
            low_next_ff <= low_next_in;
            ready_ff    <= ready_in;
            skip_ff     <= skip_in;
            decoding_ff <= decoding_in;
            widx_ff     <= widx_in;
            pend_ff     <= pend_in;
            len_ff      <= len_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_byte_valid   = out_ff.byte_valid;
   assign rsp_byte_index   = out_ff.byte_index;
   assign rsp_byte_value   = out_ff.byte_value;
   assign rsp_packet_done  = out_ff.packet_done;
   assign rsp_ati_seen     = out_ff.ati_seen;
   assign rsp_receipt_seen = out_ff.receipt_seen;
   assign rsp_receipt_ack  = out_ff.receipt_ack;
   assign rsp_has_data     = out_ff.has_data;

endmodule
`default_nettype wire

/* design/hpr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hex packet receiver checker
// Port-level checks on the receiver, bound into every receiver instance.
// ----------------------------------------------------------------------------
module hpr_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_stall,
   input wire                           rsp_valid,
   input wire                           rsp_stall,
   input wire                           rsp_byte_valid,
   input wire [hpr_pkg::OUT_IDX_W-1:0]  rsp_byte_index,
   input wire [7:0]                     rsp_byte_value,
   input wire                           rsp_packet_done,
   input wire                           rsp_ati_seen,
   input wire                           rsp_receipt_seen,
   input wire                           rsp_has_data
);
   import hpr_pkg::*;

   // A held response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_valid) &&
         $stable(rsp_byte_index) && $stable(rsp_byte_value) &&
         $stable(rsp_has_data))
      else $error("response changed while stalled");

   // The summary flag agrees with the three flags it covers.
   a_has_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_has_data == (rsp_ati_seen | rsp_packet_done | rsp_receipt_seen))
      else $error("has_data disagrees with the flags");

   // Without a completed byte the byte fields read as zero.
   a_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_byte_index == '0 && rsp_byte_value == '0)
      else $error("byte fields set without a completed byte");

   // Requests are only held off while a response is waiting.
   a_stall_cause: assert property (@(posedge clock)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with an empty output");

   // Reset empties the output.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

endmodule

bind hex_packet_receiver hpr_checker u_hpr_checker (.*);
`default_nettype wire
